/* rtl/interpolated_percentile_rank_core_macros.svh */
// Assertion macros used by the checker file, ipr_checker.sv.
// Each macro expands to one labeled concurrent assertion on clk_i / rst_ni.
`ifndef INTERPOLATED_PERCENTILE_RANK_CORE_MACROS_SVH
`define INTERPOLATED_PERCENTILE_RANK_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define IPR_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed: %m");

// Implication with the consequent in the next cycle.
`define IPR_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed: %m");

`endif

/* rtl/ipr_pkg.sv */
// Shared types and constants for the interpolated percentile rank core.
// No dependencies.
package ipr_pkg;

  localparam int unsigned MaxRefs = 256;
  localparam int unsigned CntW    = $clog2(MaxRefs + 1);
  localparam int unsigned SampW   = 32;
  localparam int unsigned FracW   = 17;
  localparam int unsigned DenW    = CntW + SampW;
  localparam int unsigned RemW    = DenW + 1;
  localparam int unsigned StepW   = $clog2(FracW + 1);

  localparam logic [FracW-1:0] QHalf = FracW'(32768);

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_BELOW = 2'd1,
    ST_ABOVE = 2'd2,
    ST_NULL  = 2'd3
  } status_e;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_REF   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_RANGE_EN   = 2'd0,
    REG_RANGE_LOW  = 2'd1,
    REG_RANGE_HIGH = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_DIV  = 2'd2,
    BK_OUT  = 2'd3
  } back_state_e;

  // One finished pixel, handed from the front end to the back end.
  typedef struct packed {
    logic                    pix_null;
    logic [CntW-1:0]         n;
    logic [CntW-1:0]         b;
    logic [CntW-1:0]         e;
    logic signed [SampW-1:0] query;
    logic signed [SampW-1:0] max_below;
    logic signed [SampW-1:0] min_above;
  } job_t;

endpackage

/* rtl/ipr_front.sv */
// Front end: holds configuration, accumulates per-pixel counts and extremes.
// Depends on ipr_pkg.
module ipr_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [ipr_pkg::SampW-1:0]       cfg_data_i,
  input  logic                            acc_i,
  input  logic                            operation_i,
  input  logic signed [ipr_pkg::SampW-1:0] sample_i,
  input  logic                            is_null_i,
  input  logic                            last_i,
  output logic                            push_o,
  output ipr_pkg::job_t                   job_o
);

  logic                              range_en_q;
  logic signed [ipr_pkg::SampW-1:0]  range_lo_q, range_hi_q;
  logic signed [ipr_pkg::SampW-1:0]  query_q, query_d;
  logic                              null_q, null_d;
  logic [ipr_pkg::CntW-1:0]          n_q, n_d, b_q, b_d, e_q, e_d;
  logic signed [ipr_pkg::SampW-1:0]  maxb_q, maxb_d;
  logic signed [ipr_pkg::SampW-1:0]  mina_q, mina_d;
  logic                              ref_ok, is_ref;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_en_q <= 1'b0;
      range_lo_q <= {1'b1, {(ipr_pkg::SampW-1){1'b0}}};
      range_hi_q <= {1'b0, {(ipr_pkg::SampW-1){1'b1}}};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ipr_pkg::REG_RANGE_EN:   range_en_q <= cfg_data_i[0];
        ipr_pkg::REG_RANGE_LOW:  range_lo_q <= cfg_data_i;
        ipr_pkg::REG_RANGE_HIGH: range_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign is_ref = (operation_i == ipr_pkg::OP_REF);
  assign ref_ok = !is_null_i &&
                  !(range_en_q && ((sample_i < range_lo_q) || (sample_i > range_hi_q)));

  always_comb begin
    query_d = query_q;
    null_d  = null_q;
    n_d     = n_q;
    b_d     = b_q;
    e_d     = e_q;
    maxb_d  = maxb_q;
    mina_d  = mina_q;
    if (!is_ref) begin
      query_d = sample_i;
      null_d  = is_null_i;
      n_d     = '0;
      b_d     = '0;
      e_d     = '0;
      maxb_d  = {1'b1, {(ipr_pkg::SampW-1){1'b0}}};
      mina_d  = {1'b0, {(ipr_pkg::SampW-1){1'b1}}};
    end else if (!ref_ok) begin
      null_d = 1'b1;
    end else if (n_q < ipr_pkg::CntW'(ipr_pkg::MaxRefs)) begin
      n_d = n_q + 1'b1;
      if (sample_i < query_q) begin
        b_d = b_q + 1'b1;
        if (sample_i > maxb_q) maxb_d = sample_i;
      end else if (sample_i == query_q) begin
        e_d = e_q + 1'b1;
      end else if (sample_i < mina_q) begin
        mina_d = sample_i;
      end
    end
  end

  assign push_o = acc_i && is_ref && last_i;

  always_comb begin
    job_o.pix_null  = null_d;
    job_o.n         = n_d;
    job_o.b         = b_d;
    job_o.e         = e_d;
    job_o.query     = query_d;
    job_o.max_below = maxb_d;
    job_o.min_above = mina_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= '0;
      null_q  <= 1'b0;
      n_q     <= '0;
      b_q     <= '0;
      e_q     <= '0;
      maxb_q  <= {1'b1, {(ipr_pkg::SampW-1){1'b0}}};
      mina_q  <= {1'b0, {(ipr_pkg::SampW-1){1'b1}}};
    end else if (push_o) begin
      // clear the pixel, keep the query
      query_q <= query_d;
      null_q  <= 1'b0;
      n_q     <= '0;
      b_q     <= '0;
      e_q     <= '0;
      maxb_q  <= {1'b1, {(ipr_pkg::SampW-1){1'b0}}};
      mina_q  <= {1'b0, {(ipr_pkg::SampW-1){1'b1}}};
    end else if (acc_i) begin
      query_q <= query_d;
      null_q  <= null_d;
      n_q     <= n_d;
      b_q     <= b_d;
      e_q     <= e_d;
      maxb_q  <= maxb_d;
      mina_q  <= mina_d;
    end
  end

endmodule

/* rtl/ipr_fifo.sv */
// Two-entry job queue between front end and back end.
// Depends on ipr_pkg.
module ipr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ipr_pkg::job_t wdata_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          avail_o,
  output ipr_pkg::job_t rdata_o
);

  ipr_pkg::job_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* rtl/ipr_back.sv */
// Back end: classifies a finished pixel, forms the fraction, divides, outputs.
// Depends on ipr_pkg.
module ipr_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       avail_i,
  input  ipr_pkg::job_t              job_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [ipr_pkg::FracW-1:0]  quantile_o
);

  ipr_pkg::back_state_e state_q, state_d;
  logic [1:0]                status_q;
  logic [ipr_pkg::FracW-1:0] quant_q;
  logic [ipr_pkg::CntW-1:0]  bm1_q, nm1_q;
  logic [ipr_pkg::SampW-1:0] span_q, w_q;
  logic [ipr_pkg::DenW-1:0]  den_q;
  logic [ipr_pkg::RemW-1:0]  rem_q, trial;
  logic [ipr_pkg::StepW-1:0] step_q;
  logic                      bit_set;
  logic [ipr_pkg::SampW:0]   span_w, w_w;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      ipr_pkg::BK_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          if (job_i.pix_null || job_i.n == '0) state_d = ipr_pkg::BK_OUT;
          else if (job_i.b == '0 && job_i.e == '0) state_d = ipr_pkg::BK_OUT;
          else if (job_i.b == job_i.n) state_d = ipr_pkg::BK_OUT;
          else if (job_i.n == ipr_pkg::CntW'(1)) state_d = ipr_pkg::BK_OUT;
          else if (job_i.e != '0) state_d = ipr_pkg::BK_DIV;
          else state_d = ipr_pkg::BK_MUL;
        end
      end
      ipr_pkg::BK_MUL: state_d = ipr_pkg::BK_DIV;
      ipr_pkg::BK_DIV: begin
        if (step_q == ipr_pkg::StepW'(ipr_pkg::FracW - 1)) state_d = ipr_pkg::BK_OUT;
      end
      ipr_pkg::BK_OUT: begin
        if (!out_stall_i) state_d = ipr_pkg::BK_IDLE;
      end
      default: state_d = ipr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ipr_pkg::BK_IDLE;
    else         state_q <= state_d;
  end

  assign span_w = {job_i.min_above[ipr_pkg::SampW-1], job_i.min_above} -
                  {job_i.max_below[ipr_pkg::SampW-1], job_i.max_below};
  assign w_w    = {job_i.query[ipr_pkg::SampW-1], job_i.query} -
                  {job_i.max_below[ipr_pkg::SampW-1], job_i.max_below};

  // restoring divide, first step without shift
  assign trial   = (step_q == '0) ? rem_q : {rem_q[ipr_pkg::RemW-2:0], 1'b0};
  assign bit_set = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    case (state_q)
      ipr_pkg::BK_IDLE: begin
        step_q <= '0;
        // a single reference equal to the query gives one half
        quant_q <= (!job_i.pix_null && job_i.n == ipr_pkg::CntW'(1) &&
                    job_i.e == ipr_pkg::CntW'(1)) ? ipr_pkg::QHalf : '0;
        bm1_q  <= job_i.b - 1'b1;
        nm1_q  <= job_i.n - 1'b1;
        span_q <= span_w[ipr_pkg::SampW-1:0];
        w_q    <= w_w[ipr_pkg::SampW-1:0];
        rem_q  <= ipr_pkg::RemW'({job_i.b, 1'b0}) + ipr_pkg::RemW'(job_i.e) -
                  ipr_pkg::RemW'(1);
        den_q  <= ipr_pkg::DenW'({job_i.n - 1'b1, 1'b0});
        if (job_i.pix_null || job_i.n == '0) status_q <= ipr_pkg::ST_NULL;
        else if (job_i.b == '0 && job_i.e == '0) status_q <= ipr_pkg::ST_BELOW;
        else if (job_i.b == job_i.n) status_q <= ipr_pkg::ST_ABOVE;
        else status_q <= ipr_pkg::ST_VALID;
      end
      ipr_pkg::BK_MUL: begin
        rem_q <= ipr_pkg::RemW'(ipr_pkg::DenW'(bm1_q) * ipr_pkg::DenW'(span_q)) +
                 ipr_pkg::RemW'(w_q);
        den_q <= ipr_pkg::DenW'(nm1_q) * ipr_pkg::DenW'(span_q);
      end
      ipr_pkg::BK_DIV: begin
        rem_q   <= bit_set ? trial - {1'b0, den_q} : trial;
        quant_q <= {quant_q[ipr_pkg::FracW-2:0], bit_set};
        step_q  <= step_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = (state_q == ipr_pkg::BK_OUT);
  assign status_o    = status_q;
  assign quantile_o  = quant_q;

endmodule

/* rtl/interpolated_percentile_rank_core.sv */
// Top level of the interpolated percentile rank core.
// Depends on ipr_pkg, ipr_front, ipr_fifo, ipr_back.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o  operation, sample, is_null, last
//   out      out  out_valid_o/out_stall_i status, quantile
//   cfg      in   cfg_we_i               cfg_index_i, cfg_data_i
//
// The front end takes one item per cycle while in_stall_o is low. The back end
// pops each pixel and goes straight to output (null, below, above, single) or
// through a multiply (if no reference equals the query), 17 divide steps and
// output. A two-job queue lets the front keep accepting; in_stall_o rises
// while the queue is full. Reset is asynchronous, active low; no clearing pass.
module interpolated_percentile_rank_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [ipr_pkg::SampW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic signed [ipr_pkg::SampW-1:0] sample_i,
  input  logic                             is_null_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [ipr_pkg::FracW-1:0]        quantile_o
);

  logic          acc, push, pop, full, avail;
  ipr_pkg::job_t job_w, job_r;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;

  ipr_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .acc_i(acc), .operation_i, .sample_i, .is_null_i, .last_i,
    .push_o(push), .job_o(job_w)
  );

  ipr_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(job_w), .pop_i(pop),
    .full_o(full), .avail_o(avail), .rdata_o(job_r)
  );

  ipr_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .job_i(job_r), .pop_o(pop),
    .out_valid_o, .out_stall_i, .status_o, .quantile_o
  );

endmodule

/* rtl/ipr_checker.sv */
// Port-level checks for the interpolated percentile rank core, and its bind.
// Depends on ipr_pkg and interpolated_percentile_rank_core_macros.svh.
`include "interpolated_percentile_rank_core_macros.svh"

module ipr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [1:0]                      status_o,
  input logic [ipr_pkg::FracW-1:0]       quantile_o
);

  `IPR_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o))
  `IPR_ASSERT_IMP(a_frac_only_valid, out_valid_o && status_o != ipr_pkg::ST_VALID, quantile_o == '0)
  `IPR_ASSERT_IMP(a_frac_range, out_valid_o, quantile_o <= ipr_pkg::FracW'(65536))
  `IPR_ASSERT_NXT(a_one_beat, out_valid_o && !out_stall_i, !out_valid_o)

endmodule

bind interpolated_percentile_rank_core ipr_checker u_ipr_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .status_o, .quantile_o
);
